// ===== rtl/clpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package clpe_pkg;

  // Commands carried by an input item
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  // Status codes carried by a result item
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_WALK,
    ST_DEL_WALK,
    ST_LINK_NEW,
    ST_LINK_PREV,
    ST_DUMP,
    ST_RESP
  } state_t;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  // Walk counters cover every position and the largest pool plus one
  localparam int WALK_W  = 7;
  // Longest dump shown for one item
  localparam int MAX_RESULTS = 32;

endpackage

`default_nettype wire

// ===== rtl/circular_list_position_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    command, item_value, list_position
// out      out_valid / out_ready  status, out_value, last_result
//
// An item is taken only while the sequencer is idle; one item is worked at a time.
// Append, insert into an empty list and insert at position one write the new node
// and then link its predecessor; other inserts first make up to position-2 link reads;
// delete makes up to position-1 link reads; dump shows one element per result. One
// link read of the node memory per cycle sets the walk rate. Full, empty and
// position-zero reports skip the walk; a delete past the end reports after its walk.
// Reset (rst, synchronous) empties the list at once; the node memory is not cleared.
// A result not taken holds the sequencer in place until out_ready.

module circular_list_position_engine #(
  parameter int CAPACITY = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          command,
  input  wire logic signed [clpe_pkg::VALUE_W-1:0] item_value,
  input  wire logic [clpe_pkg::POS_W-1:0]          list_position,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               status,
  output logic signed [clpe_pkg::VALUE_W-1:0]      out_value,
  output logic                                     last_result
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [SW-1:0]                rd_addr;
  logic [clpe_pkg::VALUE_W-1:0] val_rdata;
  logic [SW-1:0]                link_rdata;
  logic [SW-1:0]                wr_addr;
  logic                         val_we;
  logic [clpe_pkg::VALUE_W-1:0] wr_val;
  logic                         link_we;
  logic [SW-1:0]                wr_link;

  // Node values and links
  clpe_node_ram #(
    .DEPTH (CAPACITY),
    .AW    (SW)
  ) u_ram (
    .clk        (clk),
    .rd_addr    (rd_addr),
    .val_rdata  (val_rdata),
    .link_rdata (link_rdata),
    .wr_addr    (wr_addr),
    .val_we     (val_we),
    .wr_val     (wr_val),
    .link_we    (link_we),
    .wr_link    (wr_link)
  );

  // List sequencer and output register
  clpe_ctrl #(
    .CAPACITY (CAPACITY),
    .SW       (SW),
    .CW       (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .item_value    (item_value),
    .list_position (list_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .out_value     (out_value),
    .last_result   (last_result),
    .rd_addr       (rd_addr),
    .val_rdata     (val_rdata),
    .link_rdata    (link_rdata),
    .wr_addr       (wr_addr),
    .val_we        (val_we),
    .wr_val        (wr_val),
    .link_we       (link_we),
    .wr_link       (wr_link)
  );

endmodule

`default_nettype wire

// ===== rtl/clpe_node_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clpe_node_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                         clk,
  input  wire logic [AW-1:0]                rd_addr,
  output logic      [clpe_pkg::VALUE_W-1:0] val_rdata,
  output logic      [AW-1:0]                link_rdata,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic                         val_we,
  input  wire logic [clpe_pkg::VALUE_W-1:0] wr_val,
  input  wire logic                         link_we,
  input  wire logic [AW-1:0]                wr_link
);

  logic [clpe_pkg::VALUE_W-1:0] val_mem [DEPTH];
  logic [AW-1:0]                link_mem [DEPTH];

  // Write node value and link
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    val_rdata  <= val_mem[rd_addr];
    link_rdata <= link_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/clpe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clpe_ctrl #(
  parameter int CAPACITY = 32,
  parameter int SW       = 5,
  parameter int CW       = 6
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          command,
  input  wire logic signed [clpe_pkg::VALUE_W-1:0] item_value,
  input  wire logic [clpe_pkg::POS_W-1:0]          list_position,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               status,
  output logic signed [clpe_pkg::VALUE_W-1:0]      out_value,
  output logic                                     last_result,
  // node memory
  output logic [SW-1:0]                            rd_addr,
  input  wire logic [clpe_pkg::VALUE_W-1:0]        val_rdata,
  input  wire logic [SW-1:0]                       link_rdata,
  output logic [SW-1:0]                            wr_addr,
  output logic                                     val_we,
  output logic [clpe_pkg::VALUE_W-1:0]             wr_val,
  output logic                                     link_we,
  output logic [SW-1:0]                            wr_link
);

  localparam int WW = clpe_pkg::WALK_W;

  clpe_pkg::state_t  state, state_next;
  clpe_pkg::cmd_t    cmd_q, cmd_q_next;
  clpe_pkg::status_t resp_status, resp_status_next;

  logic [clpe_pkg::VALUE_W-1:0] value_q, value_q_next;
  logic [clpe_pkg::POS_W-1:0]   pos_q, pos_q_next;
  logic [SW-1:0] cur, cur_next;
  logic [SW-1:0] prev, prev_next;
  logic [SW-1:0] new_slot, new_slot_next;
  logic [SW-1:0] nxt_link, nxt_link_next;
  logic [SW-1:0] link_target, link_target_next;
  logic          upd_head, upd_head_next;
  logic          upd_tail, upd_tail_next;
  logic [SW-1:0] head_slot, head_slot_next;
  logic [SW-1:0] tail_slot, tail_slot_next;
  logic [CW-1:0] elem_count, elem_count_next;
  logic [CAPACITY-1:0] in_use, in_use_next;
  logic [WW-1:0] walk_cnt, walk_cnt_next;
  logic [WW-1:0] dump_total, dump_total_next;
  logic [WW-1:0] dump_idx, dump_idx_next;

  logic [SW-1:0] free_slot;
  logic          out_free;
  logic          emit;
  clpe_pkg::status_t emit_status;
  logic [clpe_pkg::VALUE_W-1:0] emit_value;
  logic          emit_last;
  logic [WW-1:0] pos_w;
  logic [WW-1:0] count_w;
  logic          is_full;
  logic          is_empty;

  // Lowest free pool slot
  always_comb begin
    free_slot = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (!in_use[k]) begin
        free_slot = SW'(k);
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == clpe_pkg::ST_IDLE);
  assign pos_w    = WW'(pos_q);
  assign count_w  = WW'(elem_count);
  assign is_full  = (elem_count == CW'(CAPACITY));
  assign is_empty = (elem_count == '0);

  // Next state, memory access and result
  always_comb begin
    state_next       = state;
    cmd_q_next       = cmd_q;
    resp_status_next = resp_status;
    value_q_next     = value_q;
    pos_q_next       = pos_q;
    cur_next         = cur;
    prev_next        = prev;
    new_slot_next    = new_slot;
    nxt_link_next    = nxt_link;
    link_target_next = link_target;
    upd_head_next    = upd_head;
    upd_tail_next    = upd_tail;
    head_slot_next   = head_slot;
    tail_slot_next   = tail_slot;
    elem_count_next  = elem_count;
    in_use_next      = in_use;
    walk_cnt_next    = walk_cnt;
    dump_total_next  = dump_total;
    dump_idx_next    = dump_idx;

    rd_addr     = cur;
    wr_addr     = link_target;
    val_we      = 1'b0;
    wr_val      = value_q;
    link_we     = 1'b0;
    wr_link     = new_slot;
    emit        = 1'b0;
    emit_status = clpe_pkg::STAT_OK;
    emit_value  = '0;
    emit_last   = 1'b1;

    case (state)
      clpe_pkg::ST_IDLE: begin
        // Latch the item and start the walk at the head
        if (in_valid) begin
          cmd_q_next    = clpe_pkg::cmd_t'(command);
          value_q_next  = item_value;
          pos_q_next    = list_position;
          cur_next      = head_slot;
          prev_next     = head_slot;
          walk_cnt_next = WW'(1);
          new_slot_next = free_slot;
          state_next    = clpe_pkg::ST_DECODE;
        end
      end

      clpe_pkg::ST_DECODE: begin
        // Head node is being read this cycle
        case (cmd_q)
          clpe_pkg::CMD_APPEND, clpe_pkg::CMD_INSERT: begin
            if (is_full) begin
              resp_status_next = clpe_pkg::STAT_FULL;
              state_next       = clpe_pkg::ST_RESP;
            end else if (is_empty) begin
              nxt_link_next    = new_slot;
              link_target_next = new_slot;
              upd_head_next    = 1'b1;
              upd_tail_next    = 1'b1;
              state_next       = clpe_pkg::ST_LINK_NEW;
            end else if (cmd_q == clpe_pkg::CMD_APPEND) begin
              nxt_link_next    = head_slot;
              link_target_next = tail_slot;
              upd_head_next    = 1'b0;
              upd_tail_next    = 1'b1;
              state_next       = clpe_pkg::ST_LINK_NEW;
            end else if (pos_q == clpe_pkg::POS_W'(1)) begin
              nxt_link_next    = head_slot;
              link_target_next = tail_slot;
              upd_head_next    = 1'b1;
              upd_tail_next    = 1'b0;
              state_next       = clpe_pkg::ST_LINK_NEW;
            end else begin
              state_next = clpe_pkg::ST_INS_WALK;
            end
          end
          clpe_pkg::CMD_DELETE: begin
            if (is_empty) begin
              resp_status_next = clpe_pkg::STAT_EMPTY;
              state_next       = clpe_pkg::ST_RESP;
            end else if (pos_q == '0) begin
              resp_status_next = clpe_pkg::STAT_RANGE;
              state_next       = clpe_pkg::ST_RESP;
            end else begin
              state_next = clpe_pkg::ST_DEL_WALK;
            end
          end
          default: begin
            if (is_empty) begin
              resp_status_next = clpe_pkg::STAT_EMPTY;
              state_next       = clpe_pkg::ST_RESP;
            end else begin
              dump_total_next = (count_w > WW'(clpe_pkg::MAX_RESULTS)) ?
                                WW'(clpe_pkg::MAX_RESULTS) : count_w;
              dump_idx_next   = '0;
              state_next      = clpe_pkg::ST_DUMP;
            end
          end
        endcase
      end

      clpe_pkg::ST_INS_WALK: begin
        // Advance to the node after which the new one goes
        if ((pos_q != '0) && ((walk_cnt + WW'(1)) < pos_w) && (cur != tail_slot)) begin
          cur_next      = link_rdata;
          walk_cnt_next = walk_cnt + WW'(1);
          rd_addr       = link_rdata;
        end else begin
          nxt_link_next    = link_rdata;
          link_target_next = cur;
          upd_head_next    = 1'b0;
          upd_tail_next    = (cur == tail_slot);
          state_next       = clpe_pkg::ST_LINK_NEW;
        end
      end

      clpe_pkg::ST_LINK_NEW: begin
        // Write the new node with its forward link
        val_we     = 1'b1;
        link_we    = 1'b1;
        wr_addr    = new_slot;
        wr_val     = value_q;
        wr_link    = nxt_link;
        state_next = clpe_pkg::ST_LINK_PREV;
      end

      clpe_pkg::ST_LINK_PREV: begin
        // Hook the predecessor to the new node and report
        if (out_free) begin
          link_we               = 1'b1;
          wr_addr               = link_target;
          wr_link               = new_slot;
          in_use_next[new_slot] = 1'b1;
          elem_count_next       = elem_count + CW'(1);
          if (upd_head) begin
            head_slot_next = new_slot;
          end
          if (upd_tail) begin
            tail_slot_next = new_slot;
          end
          emit       = 1'b1;
          state_next = clpe_pkg::ST_IDLE;
        end
      end

      clpe_pkg::ST_DEL_WALK: begin
        if ((walk_cnt < pos_w) && (cur != tail_slot)) begin
          // Advance to the next node
          prev_next     = cur;
          cur_next      = link_rdata;
          walk_cnt_next = walk_cnt + WW'(1);
          rd_addr       = link_rdata;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = clpe_pkg::ST_IDLE;
          if (pos_q == clpe_pkg::POS_W'(1)) begin
            // Drop the head
            if (cur == tail_slot) begin
              head_slot_next = '0;
              tail_slot_next = '0;
            end else begin
              head_slot_next = link_rdata;
              link_we        = 1'b1;
              wr_addr        = tail_slot;
              wr_link        = link_rdata;
            end
            in_use_next[cur] = 1'b0;
            elem_count_next  = elem_count - CW'(1);
          end else if (walk_cnt < pos_w) begin
            emit_status = clpe_pkg::STAT_RANGE;
          end else begin
            // Unlink the node after its predecessor
            link_we = 1'b1;
            wr_addr = prev;
            wr_link = link_rdata;
            if (cur == tail_slot) begin
              tail_slot_next = prev;
            end
            in_use_next[cur] = 1'b0;
            elem_count_next  = elem_count - CW'(1);
          end
        end
      end

      clpe_pkg::ST_DUMP: begin
        // One element per result, follow the link
        if (out_free) begin
          emit          = 1'b1;
          emit_value    = val_rdata;
          emit_last     = ((dump_idx + WW'(1)) == dump_total);
          cur_next      = link_rdata;
          rd_addr       = link_rdata;
          dump_idx_next = dump_idx + WW'(1);
          if (emit_last) begin
            state_next = clpe_pkg::ST_IDLE;
          end
        end
      end

      clpe_pkg::ST_RESP: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = resp_status;
          state_next  = clpe_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = clpe_pkg::ST_IDLE;
      end
    endcase
  end

  // State and list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= clpe_pkg::ST_IDLE;
      head_slot  <= '0;
      tail_slot  <= '0;
      elem_count <= '0;
      in_use     <= '0;
    end else begin
      state      <= state_next;
      head_slot  <= head_slot_next;
      tail_slot  <= tail_slot_next;
      elem_count <= elem_count_next;
      in_use     <= in_use_next;
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    cmd_q       <= cmd_q_next;
    resp_status <= resp_status_next;
    value_q     <= value_q_next;
    pos_q       <= pos_q_next;
    cur         <= cur_next;
    prev        <= prev_next;
    new_slot    <= new_slot_next;
    nxt_link    <= nxt_link_next;
    link_target <= link_target_next;
    upd_head    <= upd_head_next;
    upd_tail    <= upd_tail_next;
    walk_cnt    <= walk_cnt_next;
    dump_total  <= dump_total_next;
    dump_idx    <= dump_idx_next;
  end

  // Output register: hold a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= emit_status;
      out_value   <= emit_value;
      last_result <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_circular_list_position_engine.sv =====
`timescale 1ns / 1ps

module tb_circular_list_position_engine;
  import clpe_pkg::*;

  localparam int LIST_CAP       = 32;
  localparam int DUMP_MAX       = MAX_RESULTS;
  localparam int STALL_LIMIT    = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RAND_PER_PHASE = 25;
  localparam int NUM_DIRECTED   = 22;

  typedef struct {
    status_t     st;
    logic [31:0] val;
    logic        last;
  } list_result_t;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] val;
    logic [5:0]  pos;
    bit          typed;
    status_t     st;
  } dir_row_t;

  // Directed rows; typed status where it is plain, dumps go through the predictor
  dir_row_t dir_tab [0:NUM_DIRECTED-1] = '{
    '{CMD_DUMP,   32'h0000_0000, 6'd0,  1'b1, STAT_EMPTY},
    '{CMD_DELETE, 32'h0000_0000, 6'd1,  1'b1, STAT_EMPTY},
    '{CMD_DELETE, 32'h0000_0000, 6'd0,  1'b1, STAT_EMPTY},
    '{CMD_INSERT, 32'h7FFF_FFFF, 6'd9,  1'b1, STAT_OK},
    '{CMD_DELETE, 32'h0000_0000, 6'd1,  1'b1, STAT_OK},
    '{CMD_DUMP,   32'h0000_0000, 6'd0,  1'b1, STAT_EMPTY},
    '{CMD_APPEND, 32'h8000_0000, 6'd0,  1'b1, STAT_OK},
    '{CMD_APPEND, 32'h7FFF_FFFF, 6'd63, 1'b1, STAT_OK},
    '{CMD_INSERT, 32'h0000_0000, 6'd1,  1'b1, STAT_OK},
    '{CMD_INSERT, 32'hFFFF_FFFF, 6'd0,  1'b1, STAT_OK},
    '{CMD_INSERT, 32'h0000_0001, 6'd63, 1'b1, STAT_OK},
    '{CMD_INSERT, 32'h5555_5555, 6'd3,  1'b1, STAT_OK},
    '{CMD_DUMP,   32'hFFFF_FFFF, 6'd63, 1'b0, STAT_OK},
    '{CMD_DELETE, 32'h0000_0000, 6'd0,  1'b1, STAT_RANGE},
    '{CMD_DELETE, 32'h0000_0000, 6'd7,  1'b1, STAT_RANGE},
    '{CMD_DELETE, 32'h0000_0000, 6'd63, 1'b1, STAT_RANGE},
    '{CMD_DELETE, 32'h0000_0000, 6'd6,  1'b1, STAT_OK},
    '{CMD_DELETE, 32'h0000_0000, 6'd1,  1'b1, STAT_OK},
    '{CMD_DELETE, 32'h0000_0000, 6'd2,  1'b1, STAT_OK},
    '{CMD_APPEND, 32'hAAAA_AAAA, 6'd0,  1'b1, STAT_OK},
    '{CMD_INSERT, 32'h1234_5678, 6'd2,  1'b1, STAT_OK},
    '{CMD_DUMP,   32'h0000_0000, 6'd0,  1'b0, STAT_OK}
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [1:0]  command       = CMD_APPEND;
  logic [31:0] item_value    = '0;
  logic [5:0]  list_position = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [1:0]  status;
  logic signed [31:0] out_value;
  logic        last_result;

  // Predicted list contents
  logic [31:0]         node_val  [LIST_CAP];
  logic [4:0]          node_next [LIST_CAP];
  logic [LIST_CAP-1:0] node_used = '0;
  int unsigned         list_head = 0;
  int unsigned         list_tail = 0;
  int unsigned         list_len  = 0;
  int unsigned         peak_len  = 0;

  list_result_t awaited_results[$];
  list_result_t op_results[$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_req       = 1'b0;
  int  items_sent     = 0;
  int  results_seen   = 0;
  int  errors         = 0;
  int  quiet_cycles   = 0;

  circular_list_position_engine #(.CAPACITY(LIST_CAP)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .item_value    (item_value),
    .list_position (list_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .out_value     (out_value),
    .last_result   (last_result)
  );

  always #1 clk = ~clk;

  // Take the lowest free slot for a new node
  function automatic int unsigned claim_slot(logic [31:0] v);
    int unsigned s;
    s = 0;
    while (s < LIST_CAP && node_used[s]) s++;
    s = s % LIST_CAP;
    node_used[s] = 1'b1;
    node_val[s]  = v;
    list_len++;
    if (list_len > peak_len) peak_len = list_len;
    return s;
  endfunction

  function automatic void free_node(int unsigned s);
    node_used[s] = 1'b0;
    if (list_len > 0) list_len--;
  endfunction

  // Append is an insert with a position past any tail
  function automatic status_t list_insert(logic [31:0] v, int unsigned pos);
    int unsigned s, t, c;
    if (list_len >= LIST_CAP) return STAT_FULL;
    if (list_len == 0) begin
      s = claim_slot(v);
      list_head = s;
      list_tail = s;
      node_next[s] = s;
      return STAT_OK;
    end
    s = claim_slot(v);
    if (pos == 1) begin
      node_next[s] = list_head;
      list_head = s;
      node_next[list_tail] = s;
      return STAT_OK;
    end
    // Position zero lands right after the head
    t = list_head;
    c = 1;
    while (pos >= 1 && c + 1 < pos && t != list_tail) begin
      t = node_next[t];
      c++;
    end
    node_next[s] = node_next[t];
    node_next[t] = s;
    if (t == list_tail) list_tail = s;
    return STAT_OK;
  endfunction

  function automatic status_t list_delete(int unsigned pos);
    int unsigned cur, prev, c;
    if (list_len == 0) return STAT_EMPTY;
    if (pos == 0) return STAT_RANGE;
    cur = list_head;
    if (pos == 1) begin
      if (list_head == list_tail) begin
        list_head = 0;
        list_tail = 0;
      end else begin
        list_head = node_next[cur];
        node_next[list_tail] = list_head;
      end
      free_node(cur);
      return STAT_OK;
    end
    prev = cur;
    c = 1;
    while (c < pos && cur != list_tail) begin
      prev = cur;
      cur = node_next[cur];
      c++;
    end
    if (c < pos) return STAT_RANGE;
    node_next[prev] = node_next[cur];
    if (cur == list_tail) list_tail = prev;
    free_node(cur);
    return STAT_OK;
  endfunction

  // Work out the results of one accepted item into op_results
  task automatic predict_list_op(cmd_t c, logic [31:0] v, logic [5:0] p);
    list_result_t r;
    int unsigned n, s, i;
    op_results.delete();
    r.val  = '0;
    r.last = 1'b1;
    r.st   = STAT_OK;
    case (c)
      CMD_APPEND: begin
        r.st = list_insert(v, 2 * LIST_CAP);
        op_results.push_back(r);
      end
      CMD_INSERT: begin
        r.st = list_insert(v, p);
        op_results.push_back(r);
      end
      CMD_DELETE: begin
        r.st = list_delete(p);
        op_results.push_back(r);
      end
      default: begin
        if (list_len == 0) begin
          r.st = STAT_EMPTY;
          op_results.push_back(r);
        end else begin
          n = (list_len > DUMP_MAX) ? DUMP_MAX : list_len;
          s = list_head;
          for (i = 0; i < n; i++) begin
            r.val  = node_val[s];
            r.last = (i + 1 == n);
            op_results.push_back(r);
            s = node_next[s];
          end
        end
      end
    endcase
  endtask

  // Offer one item, hold it until accepted, then queue its expected results
  task automatic offer_item(cmd_t c, logic [31:0] v, logic [5:0] p, bit typed,
                            status_t st);
    list_result_t r;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    command       <= c;
    item_value    <= v;
    list_position <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_list_op(c, v, p);
    if (typed) begin
      r.st   = st;
      r.val  = '0;
      r.last = 1'b1;
      awaited_results.push_back(r);
    end else begin
      foreach (op_results[i]) awaited_results.push_back(op_results[i]);
    end
    items_sent++;
  endtask

  task automatic offer_random_item();
    cmd_t        c;
    logic [31:0] v;
    logic [5:0]  p;
    int unsigned r, del_w;
    // Lean toward deletes when the pool runs high
    r = $urandom_range(99);
    del_w = (list_len > 24) ? 45 : 20;
    if (r < del_w) c = CMD_DELETE;
    else if (r < del_w + 12) c = CMD_DUMP;
    else if (r[0]) c = CMD_APPEND;
    else c = CMD_INSERT;
    case ($urandom_range(7))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      default: v = $urandom();
    endcase
    if ($urandom_range(4) == 0) p = 6'($urandom_range(63));
    else p = 6'($urandom_range(list_len + 1));
    offer_item(c, v, p, 1'b0, STAT_OK);
  endtask

  // Drop valid and wait until every expected item is back
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive out_ready; a requested hold-off is counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Check each result against the oldest expectation; watch for lack of progress
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: status=%0d value=%0d last=%0b",
                   $time, status, out_value, last_result);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.st || out_value !== want.val ||
              last_result !== want.last) begin
            errors++;
            $display("%0t: mismatch: expected status=%0d value=%0d last=%0b, got status=%0d value=%0d last=%0b",
                     $time, want.st, $signed(want.val), want.last,
                     status, out_value, last_result);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, awaited_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: empty list, extremes, every command and the empty and range codes
    foreach (dir_tab[i])
      offer_item(dir_tab[i].cmd, dir_tab[i].val, dir_tab[i].pos, dir_tab[i].typed,
                 dir_tab[i].st);

    // Fill the pool, then hit it while full, dump the whole list and delete its last node
    while (list_len < LIST_CAP) begin
      if ($urandom_range(1) == 0)
        offer_item(CMD_APPEND, $urandom(), 6'd0, 1'b0, STAT_OK);
      else
        offer_item(CMD_INSERT, $urandom(), 6'($urandom_range(list_len + 1)), 1'b0,
                   STAT_OK);
    end
    offer_item(CMD_APPEND, 32'h0000_0001, 6'd0, 1'b1, STAT_FULL);
    offer_item(CMD_INSERT, 32'hFFFF_FFFE, 6'd1, 1'b1, STAT_FULL);
    offer_item(CMD_DUMP, 32'h0000_0000, 6'd0, 1'b0, STAT_OK);
    offer_item(CMD_DELETE, 32'h0000_0000, 6'd32, 1'b0, STAT_OK);
    drain_and_settle();

    // Sender gaps only
    send_idle_pct = 77;
    repeat (RAND_PER_PHASE) offer_random_item();
    drain_and_settle();

    // Receiver stalls, starting with a long hold-off under a steady sender
    send_idle_pct  = 0;
    recv_stall_pct = 77;
    hold_req = 1'b1;
    repeat (RAND_PER_PHASE) offer_random_item();
    drain_and_settle();

    // Both sides idle
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    repeat (RAND_PER_PHASE) offer_random_item();
    drain_and_settle();

    // Back to back
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (RAND_PER_PHASE) offer_random_item();
    drain_and_settle();

    $display("Run covered %0d items (%0d directed rows, pool filled to %0d of %0d slots)",
             items_sent, NUM_DIRECTED, peak_len, LIST_CAP);
    $display("%0d results checked over steady, gapped, stalled and mixed traffic, %0d errors",
             results_seen, errors);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/clpe_pkg.sv
rtl/clpe_node_ram.sv
rtl/clpe_ctrl.sv
rtl/circular_list_position_engine.sv
sim/tb_circular_list_position_engine.sv
